// ===== src/srdm_pkg.sv =====
// Shared types and constants for the stream rate dropout monitor.
package srdm_pkg;

   localparam int RATE_BITS     = 10;
   localparam int MIN_BITS      = 24;
   localparam int OP_BITS       = 2;
   localparam int BYTE_CNT_BITS = 21;
   localparam int BITS_PER_BYTE = 8;
   localparam int DROPOUT_MIN_RESET = 100 * 1000;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RATE   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DROPMIN = 1'b1;

   localparam logic [OP_BITS-1:0] OP_SAMPLE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DATA    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LOST    = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CONNECT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_UPDATE,
      ST_OUT
   } srdm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture item, scale elapsed time by rate/8
      logic div_step;  // one quotient bit
      logic div2_load; // start divide by rate
      logic update;    // commit state, fill result register
   } srdm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
   } srdm_status_type;

endpackage

// ===== src/srdm_if.sv =====
// Valid/ready channel interface carrying one payload.
interface srdm_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/srdm_ctrl.sv =====
// Controller sequencing the scaling step, the iterative divide and the state update.
module srdm_ctrl
   import srdm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   output logic            out_valid,
   input  logic            out_ready,
   input  srdm_status_type status,
   output srdm_cmd_type    cmd
);
   srdm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            // scaled elapsed time is ready; form the offset and start the divide
            cmd.div2_load = 1'b1;
            state_in      = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               cmd.div_step = 1'b0;
               state_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== src/srdm_dp.sv =====
// Datapath: schedule offset via a shift and a restoring divide, dropout and loss state.
module srdm_dp
   import srdm_pkg::*;
#(
   parameter int TIME_BITS  = 48,
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srdm_cmd_type                  cmd,
   output srdm_status_type               status,
   input  logic                          csr_we,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [MIN_BITS-1:0]           csr_wdata,
   input  logic [OP_BITS-1:0]            op,
   input  logic [TIME_BITS-1:0]          now_us,
   input  logic [BYTE_CNT_BITS-1:0]      byte_count,
   output logic                          started,
   output logic signed [TIME_BITS-1:0]   offset_us,
   output logic                          dropout_reported,
   output logic [TIME_BITS-1:0]          dropout_length_us,
   output logic signed [TIME_BITS-1:0]   dropout_depth_us,
   output logic [COUNT_BITS-1:0]         dropout_total,
   output logic [TIME_BITS-1:0]          longest_dropout_us,
   output logic signed [TIME_BITS-1:0]   deepest_dropout_us,
   output logic [COUNT_BITS-1:0]         disconnects,
   output logic [TIME_BITS-1:0]          disconnected_us
);
   // dividends: |el|*rate < 2^(T+10); (tot +- |el|*rate/8)*8 < 2^(T+11)
   localparam int DW   = TIME_BITS + RATE_BITS + 1;
   localparam int CW   = $clog2(DW + 1);
   localparam int SW   = TIME_BITS + 2;   // signed working width
   localparam int BYTE_SHIFT = $clog2(BITS_PER_BYTE);
   localparam logic [TIME_BITS-1:0] TMAX = '1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic signed [SW-1:0] SPOS = SW'({1'b0, {(TIME_BITS-1){1'b1}}});
   localparam logic signed [SW-1:0] SNEG = -SPOS - SW'(1);

   logic [RATE_BITS-1:0] rate_ff;
   logic [MIN_BITS-1:0]  dmin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_BITS'(1);
         dmin_ff <= MIN_BITS'(DROPOUT_MIN_RESET);
      end else if (csr_we) begin
         if (csr_index == CSR_RATE) rate_ff <= csr_wdata[RATE_BITS-1:0];
         else                        dmin_ff <= csr_wdata;
      end
   end

   wire [RATE_BITS-1:0] rate_eff = (rate_ff == '0) ? RATE_BITS'(1) : rate_ff;

   // item capture
   logic [OP_BITS-1:0]       op_ff;
   logic [TIME_BITS-1:0]     now_ff;
   logic [BYTE_CNT_BITS-1:0] cnt_ff;

   // persistent state
   logic has_started_ff, loss_pending_ff, link_alive_ff;
   logic [TIME_BITS-1:0] start_stamp_ff, bytes_total_ff, drop_begin_ff, max_len_ff;
   logic [TIME_BITS-1:0] loss_time_ff, loss_stamp_ff;
   logic signed [TIME_BITS-1:0] prev_off_ff, drop_low_ff, min_depth_ff;
   logic [COUNT_BITS-1:0] drop_cnt_ff, loss_cnt_ff;

   // divider
   logic [DW-1:0]        quo_ff, rem_ff;
   logic [RATE_BITS-1:0] dvs_ff;
   logic [CW-1:0]        cnt_div_ff;
   logic                 neg_ff;      // sign of current quotient
   logic                 el_neg_ff;

   // elapsed magnitude and sign
   wire                 el_back = now_us < start_stamp_ff;
   wire [TIME_BITS-1:0] el_mag  = el_back ? start_stamp_ff - now_us : now_us - start_stamp_ff;
   wire [DW-1:0]        el_prod = DW'(el_mag) * DW'(rate_eff);

   // q1 = |el|*rate/8 ; off = tot - sgn*q1 ; then divide |off|*8 by rate
   wire [DW-1:0] q1 = quo_ff;
   wire [DW:0]   tot_x = (DW+1)'(bytes_total_ff);
   wire [DW:0]   q1_x  = (DW+1)'(q1);
   // el positive -> off = tot - q1 ; el negative -> off = tot + q1
   wire [DW:0]   sum_mag = tot_x + q1_x;
   wire          sub_neg = q1_x > tot_x;
   wire [DW:0]   sub_mag = sub_neg ? q1_x - tot_x : tot_x - q1_x;
   wire [DW:0]   off_mag = el_neg_ff ? sum_mag : sub_mag;
   wire          off_neg = el_neg_ff ? 1'b0 : sub_neg;

   // one restoring step
   wire [DW:0]   trial    = {rem_ff, quo_ff[DW-1]};
   wire          fits     = trial >= (DW+1)'(dvs_ff);
   wire [DW:0]   rem_next = fits ? trial - (DW+1)'(dvs_ff) : trial;

   assign status.div_done = (cnt_div_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op;
         now_ff     <= now_us;
         cnt_ff     <= byte_count;
         // /8 on the magnitude is a plain shift
         quo_ff     <= el_prod >> BYTE_SHIFT;
         el_neg_ff  <= el_back;
      end else if (cmd.div2_load) begin
         quo_ff     <= DW'(off_mag << BYTE_SHIFT);
         rem_ff     <= '0;
         dvs_ff     <= rate_eff;
         cnt_div_ff <= CW'(DW);
         neg_ff     <= off_neg;
      end else if (cmd.div_step) begin
         quo_ff     <= {quo_ff[DW-2:0], fits};
         rem_ff     <= rem_next[DW-1:0];
         cnt_div_ff <= cnt_div_ff - CW'(1);
      end
   end

   // saturated offset from the quotient
   logic signed [TIME_BITS-1:0] off_sat;
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > DW'(SPOS) + DW'(1)) off_sat = SNEG[TIME_BITS-1:0];
         else off_sat = TIME_BITS'(-$signed({1'b0, quo_ff}));
      end else begin
         if (quo_ff > DW'(SPOS)) off_sat = SPOS[TIME_BITS-1:0];
         else off_sat = quo_ff[TIME_BITS-1:0];
      end
   end

   wire signed [TIME_BITS-1:0] off_v = has_started_ff ? off_sat : '0;
   wire open_drop  = has_started_ff && off_v < 0 && prev_off_ff >= 0;
   wire close_drop = has_started_ff && off_v >= 0 && prev_off_ff < 0;
   wire [TIME_BITS-1:0] len = (now_ff >= drop_begin_ff) ? now_ff - drop_begin_ff : '0;
   wire new_len   = max_len_ff < len;
   wire new_depth = min_depth_ff > drop_low_ff;
   wire interesting = close_drop &&
                      (len >= TIME_BITS'(dmin_ff) || new_len || new_depth);
   wire signed [TIME_BITS-1:0] low_base = open_drop ? '0 : drop_low_ff;

   wire is_read = (op_ff == OP_DATA) || (op_ff == OP_LOST);
   wire [TIME_BITS-1:0] loss_d = (now_ff >= loss_stamp_ff) ? now_ff - loss_stamp_ff : '0;
   wire [TIME_BITS:0] lt_sum = {1'b0, loss_time_ff} + {1'b0, loss_d};
   wire [TIME_BITS:0] bt_sum = {1'b0, bytes_total_ff} + (TIME_BITS+1)'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         has_started_ff  <= 1'b0;
         loss_pending_ff <= 1'b0;
         link_alive_ff   <= 1'b0;
         start_stamp_ff  <= '0;
         bytes_total_ff  <= '0;
         drop_begin_ff   <= '0;
         max_len_ff      <= '0;
         loss_time_ff    <= '0;
         loss_stamp_ff   <= '0;
         prev_off_ff     <= '0;
         drop_low_ff     <= '0;
         min_depth_ff    <= '0;
         drop_cnt_ff     <= '0;
         loss_cnt_ff     <= '0;
      end else if (cmd.update) begin
         if (has_started_ff) begin
            if (open_drop) drop_begin_ff <= now_ff;
            if (close_drop) begin
               drop_begin_ff <= '0;
               if (new_len) max_len_ff <= len;
               if (new_depth) min_depth_ff <= drop_low_ff;
               if (interesting && drop_cnt_ff != CMAX) drop_cnt_ff <= drop_cnt_ff + 1'b1;
            end
            drop_low_ff <= (off_v < low_base) ? off_v : low_base;
            prev_off_ff <= off_v;
         end
         if (is_read) begin
            if (!has_started_ff) begin
               has_started_ff <= 1'b1;
               start_stamp_ff <= now_ff;
            end
            if (loss_pending_ff) begin
               loss_time_ff    <= lt_sum[TIME_BITS] ? TMAX : lt_sum[TIME_BITS-1:0];
               loss_pending_ff <= 1'b0;
            end
            if (op_ff == OP_DATA) begin
               bytes_total_ff <= bt_sum[TIME_BITS] ? TMAX : bt_sum[TIME_BITS-1:0];
            end else if (link_alive_ff) begin
               loss_stamp_ff   <= now_ff;
               loss_pending_ff <= 1'b1;
               if (loss_cnt_ff != CMAX) loss_cnt_ff <= loss_cnt_ff + 1'b1;
               link_alive_ff   <= 1'b0;
            end
         end else if (op_ff == OP_CONNECT) begin
            link_alive_ff <= 1'b1;
         end
      end
   end

   // result register (per-item fields)
   logic signed [TIME_BITS-1:0] off_out_ff, depth_out_ff;
   logic [TIME_BITS-1:0] len_out_ff;
   logic rep_out_ff;
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         off_out_ff   <= off_v;
         rep_out_ff   <= interesting;
         len_out_ff   <= close_drop ? len : '0;
         depth_out_ff <= close_drop ? drop_low_ff : '0;
      end
   end

   assign started            = has_started_ff;
   assign offset_us          = off_out_ff;
   assign dropout_reported   = rep_out_ff;
   assign dropout_length_us  = len_out_ff;
   assign dropout_depth_us   = depth_out_ff;
   assign dropout_total      = drop_cnt_ff;
   assign longest_dropout_us = max_len_ff;
   assign deepest_dropout_us = min_depth_ff;
   assign disconnects        = loss_cnt_ff;
   assign disconnected_us    = loss_time_ff;
endmodule

// ===== src/stream_rate_dropout_monitor.sv =====
// Sequence from accept to result taken: the offset is formed from elapsed*rate/8
// (a shift), then a bit-serial restoring divide by the rate runs, then the state
// is updated and the result is held until taken.
// The block holds one item at a time; the next item is accepted once the result
// is taken.
// Reset: synchronous, active high; clears all monitor state, rate to 1 and
// minimum dropout length to 100000 us.
module stream_rate_dropout_monitor
   import srdm_pkg::*;
#(
   parameter int TIME_BITS  = 48,
   parameter int COUNT_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [MIN_BITS-1:0]      csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_BITS-1:0]       req_op,
   input  logic [TIME_BITS-1:0]     req_now_us,
   input  logic [BYTE_CNT_BITS-1:0] req_byte_count,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_started,
   output logic signed [TIME_BITS-1:0] rsp_offset_us,
   output logic                     rsp_dropout_reported,
   output logic [TIME_BITS-1:0]     rsp_dropout_length_us,
   output logic signed [TIME_BITS-1:0] rsp_dropout_depth_us,
   output logic [COUNT_BITS-1:0]    rsp_dropout_total,
   output logic [TIME_BITS-1:0]     rsp_longest_dropout_us,
   output logic signed [TIME_BITS-1:0] rsp_deepest_dropout_us,
   output logic [COUNT_BITS-1:0]    rsp_disconnects,
   output logic [TIME_BITS-1:0]     rsp_disconnected_us
);
   srdm_cmd_type    cmd;
   srdm_status_type status;

   // controller: idle -> offset setup -> divide -> update -> hold result
   srdm_ctrl u_ctrl (
      .clock, .reset,
      .in_valid (req_valid), .in_ready (req_ready),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .status, .cmd
   );

   // item fields are latched on the accept cycle (cmd.load)
   srdm_dp #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock, .reset, .cmd, .status,
      .csr_we, .csr_index, .csr_wdata,
      .op(req_op), .now_us(req_now_us), .byte_count(req_byte_count),
      .started(rsp_started), .offset_us(rsp_offset_us),
      .dropout_reported(rsp_dropout_reported),
      .dropout_length_us(rsp_dropout_length_us),
      .dropout_depth_us(rsp_dropout_depth_us),
      .dropout_total(rsp_dropout_total),
      .longest_dropout_us(rsp_longest_dropout_us),
      .deepest_dropout_us(rsp_deepest_dropout_us),
      .disconnects(rsp_disconnects),
      .disconnected_us(rsp_disconnected_us)
   );

   // never accept while a result is held
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   // an accepted item cannot show its result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");

   // deepest dropout never positive
   a_depth_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_deepest_dropout_us > 0)) else $error("deepest positive");
endmodule

// ===== tb/srdm_tb_pkg.sv =====
// Item layouts for the request and result channels of the testbench.
`timescale 1ns / 1ps
package srdm_tb_pkg;
   import srdm_pkg::*;

   localparam int TB_TIME_BITS  = 48;
   localparam int TB_COUNT_BITS = 32;

   typedef struct packed {
      logic [OP_BITS-1:0]       op;
      logic [TB_TIME_BITS-1:0]  now_us;
      logic [BYTE_CNT_BITS-1:0] byte_count;
   } event_item_type;

   typedef struct packed {
      logic                           started;
      logic signed [TB_TIME_BITS-1:0] offset_us;
      logic                           dropout_reported;
      logic [TB_TIME_BITS-1:0]        dropout_length_us;
      logic signed [TB_TIME_BITS-1:0] dropout_depth_us;
      logic [TB_COUNT_BITS-1:0]       dropout_total;
      logic [TB_TIME_BITS-1:0]        longest_dropout_us;
      logic signed [TB_TIME_BITS-1:0] deepest_dropout_us;
      logic [TB_COUNT_BITS-1:0]       disconnects;
      logic [TB_TIME_BITS-1:0]        disconnected_us;
   } status_item_type;
endpackage

// ===== tb/srdm_status_checker.sv =====
// Watches the event and status channels, predicts each status item and compares.
`timescale 1ns / 1ps
module srdm_status_checker
   import srdm_pkg::*;
   import srdm_tb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [MIN_BITS-1:0]     csr_wdata,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  event_item_type          req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  status_item_type         rsp_data,
   output int                      fail_count,
   output int                      pending_count
);
   localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] C_MAX = 32'hFFFF_FFFF;

   logic [RATE_BITS-1:0] rate_mbps;
   logic [MIN_BITS-1:0]  min_drop_us;
   logic                 started, loss_open, link_up;
   logic [47:0]          t_start, total_bytes, drop_start, longest, loss_acc, loss_at;
   logic signed [47:0]   last_off, drop_floor, deepest;
   logic [31:0]          drop_cnt, loss_cnt;
   status_item_type      status_q[$];

   assign pending_count = status_q.size();

   function automatic logic signed [47:0] schedule_offset(logic [47:0] now);
      logic signed [127:0] el, q, off;
      int r;
      r   = (rate_mbps == 0) ? 1 : int'(rate_mbps);
      el  = $signed({80'd0, now}) - $signed({80'd0, t_start});
      q   = (el * r) / 8;
      off = $signed({80'd0, total_bytes}) - q;
      off = (off * 8) / r;
      if (off > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (off < -128'sh8000_0000_0000) return 48'sh8000_0000_0000;
      return off[47:0];
   endfunction

   function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
      return (b > T_MAX - a) ? T_MAX : a + b;
   endfunction

   function automatic status_item_type predict_status(event_item_type ev);
      status_item_type s;
      logic [47:0] len, d;
      logic interesting;
      s = '0;
      if (started) begin
         s.offset_us = schedule_offset(ev.now_us);
         if (s.offset_us < 0 && last_off >= 0) begin
            drop_start = ev.now_us;
            drop_floor = '0;
         end else if (s.offset_us >= 0 && last_off < 0) begin
            len = (ev.now_us >= drop_start) ? ev.now_us - drop_start : 48'd0;
            interesting = (len >= 48'(min_drop_us));
            if (longest < len) begin
               longest = len;
               interesting = 1'b1;
            end
            if (deepest > drop_floor) begin
               deepest = drop_floor;
               interesting = 1'b1;
            end
            if (interesting && drop_cnt != C_MAX) drop_cnt++;
            s.dropout_reported  = interesting;
            s.dropout_length_us = len;
            s.dropout_depth_us  = drop_floor;
            drop_start = '0;
         end
         if (s.offset_us < drop_floor) drop_floor = s.offset_us;
         last_off = s.offset_us;
      end
      if (ev.op == OP_DATA || ev.op == OP_LOST) begin
         if (!started) begin
            started = 1'b1;
            t_start = ev.now_us;
         end
         if (loss_open) begin
            d = (ev.now_us >= loss_at) ? ev.now_us - loss_at : 48'd0;
            loss_acc  = add_sat48(loss_acc, d);
            loss_open = 1'b0;
         end
         if (ev.op == OP_DATA) begin
            total_bytes = add_sat48(total_bytes, 48'(ev.byte_count));
         end else if (link_up) begin
            loss_at   = ev.now_us;
            loss_open = 1'b1;
            if (loss_cnt != C_MAX) loss_cnt++;
            link_up   = 1'b0;
         end
      end else if (ev.op == OP_CONNECT) begin
         link_up = 1'b1;
      end
      s.started            = started;
      s.dropout_total      = drop_cnt;
      s.longest_dropout_us = longest;
      s.deepest_dropout_us = deepest;
      s.disconnects        = loss_cnt;
      s.disconnected_us    = loss_acc;
      return s;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      status_item_type e;
      if (reset) begin
         rate_mbps   = RATE_BITS'(1);
         min_drop_us = MIN_BITS'(DROPOUT_MIN_RESET);
         {started, loss_open, link_up} = '0;
         {t_start, total_bytes, drop_start, longest, loss_acc, loss_at} = '0;
         {last_off, drop_floor, deepest} = '0;
         {drop_cnt, loss_cnt} = '0;
         status_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_RATE) rate_mbps = csr_wdata[RATE_BITS-1:0];
            else if (csr_index == CSR_DROPMIN) min_drop_us = csr_wdata;
         end
         if (req_valid && req_ready) status_q.push_back(predict_status(req_data));
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $display("%0t: unexpected status item, expected none actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               e = status_q.pop_front();
               check_field("started", e.started, rsp_data.started);
               check_field("offset_us", e.offset_us, rsp_data.offset_us);
               check_field("dropout_reported", e.dropout_reported,
                           rsp_data.dropout_reported);
               check_field("dropout_length_us", e.dropout_length_us,
                           rsp_data.dropout_length_us);
               check_field("dropout_depth_us", e.dropout_depth_us,
                           rsp_data.dropout_depth_us);
               check_field("dropout_total", e.dropout_total, rsp_data.dropout_total);
               check_field("longest_dropout_us", e.longest_dropout_us,
                           rsp_data.longest_dropout_us);
               check_field("deepest_dropout_us", e.deepest_dropout_us,
                           rsp_data.deepest_dropout_us);
               check_field("disconnects", e.disconnects, rsp_data.disconnects);
               check_field("disconnected_us", e.disconnected_us,
                           rsp_data.disconnected_us);
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

// ===== tb/stream_rate_dropout_monitor_tb.sv =====
// Top of the dropout monitor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module stream_rate_dropout_monitor_tb;
   import srdm_pkg::*;
   import srdm_tb_pkg::*;

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [MIN_BITS-1:0]     csr_wdata;
   int   fail_count, pending_count;
   logic long_hold;          // asks the receiver for one long hold-off
   logic [47:0] cur_now;     // running timestamp of the generated stream
   int   cur_rate;           // rate the stream is shaped for

   srdm_if #(.payload_type(event_item_type))  req_ch ();
   srdm_if #(.payload_type(status_item_type)) rsp_ch ();

   stream_rate_dropout_monitor u_top (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_ch.valid),
      .req_ready              (req_ch.ready),
      .req_op                 (req_ch.data.op),
      .req_now_us             (req_ch.data.now_us),
      .req_byte_count         (req_ch.data.byte_count),
      .rsp_valid              (rsp_ch.valid),
      .rsp_ready              (rsp_ch.ready),
      .rsp_started            (rsp_ch.data.started),
      .rsp_offset_us          (rsp_ch.data.offset_us),
      .rsp_dropout_reported   (rsp_ch.data.dropout_reported),
      .rsp_dropout_length_us  (rsp_ch.data.dropout_length_us),
      .rsp_dropout_depth_us   (rsp_ch.data.dropout_depth_us),
      .rsp_dropout_total      (rsp_ch.data.dropout_total),
      .rsp_longest_dropout_us (rsp_ch.data.longest_dropout_us),
      .rsp_deepest_dropout_us (rsp_ch.data.deepest_dropout_us),
      .rsp_disconnects        (rsp_ch.data.disconnects),
      .rsp_disconnected_us    (rsp_ch.data.disconnected_us)
   );

   srdm_status_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_data      (req_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_data      (rsp_ch.data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Generous cap; the slowest legal run is a few ms.
   initial begin
      #60_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Receiver: stall patterns drawn in turn from four random modes, plus one long
   // hold-off on request so the block fills and stalls its input.
   initial begin
      int mode;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat (64) begin
            @(negedge clock);
            if (long_hold) begin
               rsp_ch.ready <= 1'b0;
               repeat (400) @(negedge clock);
               long_hold = 1'b0;
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;                        // no stalls
               1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
               2: rsp_ch.ready <= ($urandom_range(0, 4) == 0); // mostly stalled
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [MIN_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Drive one item and hold it until the handshake; valid stays high.
   task automatic send_event(logic [OP_BITS-1:0] op, logic [47:0] now, int unsigned cnt);
      @(negedge clock);
      req_ch.valid           <= 1'b1;
      req_ch.data.op         <= op;
      req_ch.data.now_us     <= now;
      req_ch.data.byte_count <= cnt[BYTE_CNT_BITS-1:0];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drop_valid(int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Wait for the block to drain before a register write.
   task automatic settle();
      drop_valid(1);
      wait (pending_count == 0);
      repeat (130) @(posedge clock);
   endtask

   task automatic set_rate(int rate, int min_us);
      settle();
      write_csr(CSR_RATE, MIN_BITS'(rate));
      write_csr(CSR_DROPMIN, MIN_BITS'(min_us));
      cur_rate = (rate == 0) ? 1 : rate;
   endtask

   // One random item of a roughly on-schedule stream with outages and noise.
   task automatic random_event();
      int unsigned pick, dt, cnt;
      logic [OP_BITS-1:0] op;
      pick = $urandom_range(0, 99);
      dt   = $urandom_range(1, 3000);
      cnt  = 0;
      op   = OP_SAMPLE;
      if (pick < 65) begin
         op  = OP_DATA;
         cnt = (dt * cur_rate / 8) * $urandom_range(40, 170) / 100;
         if (pick < 3) cnt = $urandom_range(0, (1 << BYTE_CNT_BITS) - 1);
         if (cnt > (1 << BYTE_CNT_BITS) - 1) cnt = (1 << BYTE_CNT_BITS) - 1;
      end else if (pick < 75) begin
         op = OP_SAMPLE;
      end else if (pick < 83) begin
         op = OP_LOST;
      end else if (pick < 91) begin
         op = OP_CONNECT;
      end else if (pick < 97) begin
         dt = $urandom_range(20_000, 400_000);   // outage
         op = ($urandom_range(0, 1) == 0) ? OP_SAMPLE : OP_LOST;
      end
      if (pick == 97 && cur_now > 48'd10_000) cur_now = cur_now - 48'($urandom_range(1, 8000));
      else if (pick == 98) cur_now = 48'({$urandom, $urandom});
      else cur_now = cur_now + 48'(dt);
      if (cur_now == 0) cur_now = 1;
      send_event(op, cur_now, cnt);
   endtask

   task automatic random_phase(int items);
      int burst;
      burst = 0;
      for (int i = 0; i < items; i++) begin
         if (i == items / 3) long_hold = 1'b1;
         if (i == 2 * items / 3) begin
            drop_valid(1);
            wait (pending_count == 0);    // sender pause until drained
         end
         random_event();
         if (burst == 0) begin
            burst = $urandom_range(1, 30);
            drop_valid($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200));
         end else begin
            burst--;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_RATE;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.data    = '0;
      long_hold      = 1'b0;
      cur_rate       = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, all ops, before-start, field extremes,
      // a long outage, time going backwards, top of the timestamp range.
      send_event(OP_SAMPLE,  48'd1, 0);
      send_event(OP_CONNECT, 48'd5, 0);
      send_event(OP_DATA,    48'd10, 0);           // starts, zero bytes
      send_event(OP_SAMPLE,  48'd500, 0);          // falls behind
      send_event(OP_DATA,    48'd600, 1048576);    // catches up; dropout ends on the next item
      send_event(OP_LOST,    48'd700, 0);          // disconnect
      send_event(OP_LOST,    48'd800, 0);          // already dead
      send_event(OP_DATA,    48'd900, (1 << BYTE_CNT_BITS) - 1);
      send_event(OP_SAMPLE,  48'd500_000_000, 0);  // long outage
      send_event(OP_DATA,    48'd500_000_100, 1048576);
      send_event(OP_SAMPLE,  48'd400, 0);          // backwards in time
      send_event(OP_DATA,    48'd300, 5);
      send_event(OP_CONNECT, 48'hFFFF_FFFF_FFFF, 0);
      send_event(OP_SAMPLE,  48'hFFFF_FFFF_FFFF, 0);
      send_event(OP_LOST,    48'hFFFF_FFFF_FFFF, 0);
      send_event(OP_DATA,    48'h8000_0000_0000, 0);
      set_rate(0, 0);                              // zero rate acts as one
      send_event(OP_SAMPLE,  48'h8000_0000_1000, 0);
      send_event(OP_DATA,    48'h8000_0000_2000, 1048576);
      set_rate(1023, 16777215);
      send_event(OP_SAMPLE,  48'h8000_0001_0000, 0);
      send_event(OP_DATA,    48'h8000_0001_0100, 1048576);
      send_event(OP_SAMPLE,  48'd2, 0);

      cur_now = 48'($urandom_range(1, 1_000_000));
      set_rate(1, DROPOUT_MIN_RESET);
      random_phase(300);
      set_rate(1000, 0);
      random_phase(300);
      set_rate(0, 16777215);
      random_phase(300);
      set_rate(1023, 5000);
      random_phase(300);
      set_rate($urandom_range(1, 1023), $urandom_range(0, 200_000));
      random_phase(300);
      set_rate($urandom_range(1, 64), $urandom_range(0, 16777215));
      random_phase(300);

      drop_valid(1);
      wait (pending_count == 0);
      repeat (130) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
